// ----- rtl/crc32r_pkg.sv -----
// Package for the reflected CRC-32 block: register map, reset values and byte fold.
`timescale 1ns / 1ps

package crc32r_pkg;

  localparam int unsigned CRC_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [CRC_W-1:0] POLY_RESET = 32'hDEAD_CAFE;
  localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] XOR_OUT    = 32'hFFFF_FFFF;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_POLY = 1'b0,
    REG_INIT = 1'b1
  } reg_idx_t;

  // eight shift-right steps, LSB of the byte first
  function automatic logic [CRC_W-1:0] fold_byte(
    input logic [CRC_W-1:0]  acc,
    input logic [BYTE_W-1:0] data,
    input logic [CRC_W-1:0]  poly
  );
    logic [CRC_W-1:0] r;
    logic             fb;
    r = acc;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = r[0] ^ data[k];
      r  = {1'b0, r[CRC_W-1:1]};
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/reflected_crc32_custom_poly.sv -----
// Reflected CRC-32 over a byte stream with programmable polynomial and seed.
// Checksum path: the last byte is held in the input register, then folded into the result register.
// Throughput: one byte per cycle; the eight-step fold is unrolled shift/XOR logic between
// the input register and the remainder/result registers. A last byte waits while an
// unread checksum holds the result register, which stalls the input.
// Reset (rst_n, synchronous): polynomial 0xDEADCAFE, initial value and remainder all ones,
// all pipeline stages empty.
`timescale 1ns / 1ps

module reflected_crc32_custom_poly (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [crc32r_pkg::BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // last_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [crc32r_pkg::CRC_W-1:0]  out_tdata,  // [31:0] checksum
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [crc32r_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [crc32r_pkg::CRC_W-1:0]  cfg_pwdata,
  output logic [crc32r_pkg::CRC_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import crc32r_pkg::*;

  logic [CRC_W-1:0]  poly_r, poly_nxt;
  logic [CRC_W-1:0]  init_r, init_nxt;
  logic [CRC_W-1:0]  rem_r, rem_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_data_r, s1_data_nxt;
  logic              s1_last_r, s1_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0]  out_data_r, out_data_nxt;

  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic [CRC_W-1:0]  folded;
  logic              s1_take;
  logic              in_acc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_POLY: cfg_prdata = poly_r;
      REG_INIT: cfg_prdata = init_r;
      default:  cfg_prdata = '0;
    endcase
  end

  assign folded = fold_byte(rem_r, s1_data_r, poly_r);

  // a last byte needs room in the result register; other bytes always drain
  assign s1_take   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_take;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    poly_nxt      = poly_r;
    init_nxt      = init_r;
    rem_nxt       = rem_r;
    s1_valid_nxt  = s1_valid_r;
    s1_data_nxt   = s1_data_r;
    s1_last_nxt   = s1_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr) begin
      case (cfg_idx)
        REG_POLY: poly_nxt = cfg_pwdata;
        REG_INIT: init_nxt = cfg_pwdata;
        default:  ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_take) begin
      s1_valid_nxt = 1'b0;
      if (s1_last_r) begin
        rem_nxt       = init_r;
        out_valid_nxt = 1'b1;
        out_data_nxt  = folded ^ XOR_OUT;
      end else begin
        rem_nxt = folded;
      end
    end

    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_tdata;
      s1_last_nxt  = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= POLY_RESET;
      init_r      <= INIT_RESET;
      rem_r       <= INIT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      poly_r      <= poly_nxt;
      init_r      <= init_nxt;
      rem_r       <= rem_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    s1_last_r  <= s1_last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
